@@ hw/rtl/pfa_pkg.sv @@
`default_nettype none

package pfa_pkg;

  // Frame store geometry
  localparam int MAX_PAGES = 4096;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = PAGE_W + 1;

  // Field widths of the request and response
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // Per-page flag bits
  localparam int FLAG_W          = 3;
  localparam int FLAG_ALLOC_BIT  = 0;
  localparam int FLAG_KERNEL_BIT = 1;
  localparam int FLAG_HEAP_BIT   = 2;
  localparam logic [FLAG_W-1:0] FLAGS_NONE   = 3'b000;
  localparam logic [FLAG_W-1:0] FLAGS_KERNEL = 3'b011;
  localparam logic [FLAG_W-1:0] FLAGS_HEAP   = 3'b101;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_PAGE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_PAGES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_PAGES   = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] TOTAL_PAGES_RST  = 13'd4096;
  localparam logic [CFG_W-1:0] KERNEL_PAGES_RST = 13'd0;
  localparam logic [CFG_W-1:0] HEAP_PAGES_RST   = 13'd256;

endpackage

`default_nettype wire

@@ hw/rtl/pfa_ram.sv @@
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/page_frame_allocator_core.sv @@
`default_nettype none

// Physical page frame allocator. Free frames sit on a FIFO ring of page numbers in one
// memory; three flags per page (allocated, kernel, heap) sit in a second memory. Requests
// are handled one at a time. A free passes through accept, flag check and ring push, and
// response; a failed alloc or an unused mode takes the same steps, and a successful alloc
// adds a step because the popped page's flags are read and written back after the ring
// read. An init walks every flag entry once, one per cycle. After reset the block clears
// the flag memory, one entry a cycle, with s_tready low; configuration writes are taken
// throughout. A response waiting on m_tready holds off the end of the next request only.
module page_frame_allocator_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Request: [1:0] mode, [13:2] page_number
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [pfa_pkg::IN_DATA_W-1:0]   s_tdata,
  // Response: [1:0] status, [13:2] granted_page, [26:14] free_pages_left
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [pfa_pkg::OUT_DATA_W-1:0]  m_tdata,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pfa_pkg::CFG_W-1:0]       cfg_data
);

  import pfa_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ALLOC_WR,
    ST_INIT,
    ST_RESP
  } state_t;

  state_t state;

  logic [CFG_W-1:0]    total_pages;
  logic [CFG_W-1:0]    kernel_image_pages;
  logic [CFG_W-1:0]    heap_reserve_pages;

  logic [MODE_W-1:0]   cmd_mode;
  logic [PAGE_W-1:0]   cmd_page;
  logic [PAGE_W-1:0]   head;
  logic [PAGE_W-1:0]   tail;
  logic [CNT_W-1:0]    count;
  logic [PAGE_W-1:0]   idx;
  logic [STATUS_W-1:0] res_status;
  logic [PAGE_W-1:0]   res_granted;

  logic [CNT_W-1:0]    eff_total;
  logic [CNT_W:0]      heap_end;
  logic                idx_in_total;
  logic                idx_kernel;
  logic                idx_heap;
  logic                free_ok;
  logic                sweep_last;

  logic                flag_we;
  logic [PAGE_W-1:0]   flag_waddr;
  logic [FLAG_W-1:0]   flag_wdata;
  logic [PAGE_W-1:0]   flag_raddr;
  logic [FLAG_W-1:0]   flag_q;

  logic                ring_we;
  logic [PAGE_W-1:0]   ring_waddr;
  logic [PAGE_W-1:0]   ring_wdata;
  logic [PAGE_W-1:0]   ring_q;

  pfa_ram #(.WIDTH(FLAG_W), .DEPTH(MAX_PAGES)) u_flags (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (flag_raddr),
    .rdata (flag_q)
  );

  pfa_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (head),
    .rdata (ring_q)
  );

  assign s_tready = (state == ST_IDLE);

  // Saturate total at the store depth; heap region ends after the kernel image
  assign eff_total = (total_pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_pages;
  assign heap_end  = {1'b0, kernel_image_pages} + {1'b0, heap_reserve_pages};

  // Classify the page under the init sweep
  assign idx_in_total = {1'b0, idx} < eff_total;
  assign idx_kernel   = {1'b0, idx} < kernel_image_pages;
  assign idx_heap     = {2'b00, idx} < heap_end;
  assign sweep_last   = (idx == {PAGE_W{1'b1}});

  // Free is legal only for an allocated page inside the current total, and only while the ring is not full
  assign free_ok = ({1'b0, cmd_page} < eff_total) && flag_q[FLAG_ALLOC_BIT]
                   && (count != CNT_W'(MAX_PAGES));

  // Memory port control
  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = idx;
    flag_wdata = FLAGS_NONE;
    flag_raddr = s_tdata[MODE_W +: PAGE_W];
    ring_we    = 1'b0;
    ring_waddr = tail;
    ring_wdata = idx;
    unique case (state)
      ST_CLEAR: begin
        flag_we = 1'b1;
      end
      ST_EXEC: begin
        flag_raddr = ring_q;
        if (cmd_mode == MODE_FREE && free_ok) begin
          flag_we    = 1'b1;
          flag_waddr = cmd_page;
          flag_wdata = flag_q & ~(FLAG_W'(1) << FLAG_ALLOC_BIT);
          ring_we    = 1'b1;
          ring_wdata = cmd_page;
        end
      end
      ST_ALLOC_WR: begin
        flag_we    = 1'b1;
        flag_waddr = res_granted;
        flag_wdata = flag_q | FLAGS_KERNEL;
      end
      ST_INIT: begin
        flag_we = 1'b1;
        if (idx_in_total) begin
          if (idx_kernel) begin
            flag_wdata = FLAGS_KERNEL;
          end else if (idx_heap) begin
            flag_wdata = FLAGS_HEAP;
          end else begin
            ring_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages        <= TOTAL_PAGES_RST;
      kernel_image_pages <= KERNEL_PAGES_RST;
      heap_reserve_pages <= HEAP_PAGES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOTAL_PAGES:  total_pages        <= cfg_data;
        REG_KERNEL_PAGES: kernel_image_pages <= cfg_data;
        REG_HEAP_PAGES:   heap_reserve_pages <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer, ring pointers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      idx      <= '0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop the response once taken, unless a new one is loaded below
      if (m_tvalid && m_tready && state != ST_RESP) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          idx <= idx + PAGE_W'(1);
          if (sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_mode <= s_tdata[MODE_W-1:0];
            cmd_page <= s_tdata[MODE_W +: PAGE_W];
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (cmd_mode)
            MODE_INIT: begin
              res_status  <= STATUS_OK;
              res_granted <= '0;
              head        <= '0;
              tail        <= '0;
              count       <= '0;
              idx         <= '0;
              state       <= ST_INIT;
            end
            MODE_ALLOC: begin
              if (count == '0) begin
                res_status  <= STATUS_EMPTY;
                res_granted <= '0;
                state       <= ST_RESP;
              end else begin
                res_status  <= STATUS_OK;
                res_granted <= ring_q;
                head        <= head + PAGE_W'(1);
                count       <= count - CNT_W'(1);
                state       <= ST_ALLOC_WR;
              end
            end
            MODE_FREE: begin
              res_granted <= '0;
              state       <= ST_RESP;
              if (free_ok) begin
                res_status <= STATUS_OK;
                tail       <= tail + PAGE_W'(1);
                count      <= count + CNT_W'(1);
              end else begin
                res_status <= STATUS_BAD_PAGE;
              end
            end
            default: begin
              res_status  <= STATUS_OK;
              res_granted <= '0;
              state       <= ST_RESP;
            end
          endcase
        end
        ST_ALLOC_WR: begin
          state <= ST_RESP;
        end
        ST_INIT: begin
          // Queue every page inside the total and past the reserved regions
          if (idx_in_total && !idx_kernel && !idx_heap) begin
            tail  <= tail + PAGE_W'(1);
            count <= count + CNT_W'(1);
          end
          idx <= idx + PAGE_W'(1);
          if (sweep_last) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          // Load the response once the output slot is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_DATA_W'({count, res_granted, res_status});
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pfa_checker.sv @@
`default_nettype none

module pfa_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [pfa_pkg::OUT_DATA_W-1:0]  m_tdata
);

  import pfa_pkg::*;

  logic [STATUS_W-1:0] rsp_status;
  logic [PAGE_W-1:0]   rsp_granted;
  logic [CNT_W-1:0]    rsp_free;

  assign rsp_status  = m_tdata[STATUS_W-1:0];
  assign rsp_granted = m_tdata[STATUS_W +: PAGE_W];
  assign rsp_free    = m_tdata[STATUS_W + PAGE_W +: CNT_W];

  // Stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("response changed while stalled");

  // Reset starts the flag clearing pass with nothing in flight
  assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("block not held off after reset");

  // Status code is never the unused value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rsp_status != STATUS_UNUSED)
    else $error("unused status code on response");

  // Only a successful allocation grants a page
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && rsp_status != STATUS_OK |-> rsp_granted == '0)
    else $error("page granted on failed request");

  // Free ring occupancy never exceeds the frame count
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rsp_free <= CNT_W'(MAX_PAGES))
    else $error("free count above frame count");

endmodule

bind page_frame_allocator_core pfa_checker u_pfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/frame_alloc_checker.sv @@
// Watches the request, response and configuration traffic of the page frame
// allocator, keeps its own copy of the page flags and the free list, and
// compares every response against the prediction made when its request went in.
module frame_alloc_checker
  import pfa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tready,
  // Request: [1:0] mode, [13:2] page_number
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  // Response: [1:0] status, [13:2] granted_page, [26:14] free_pages_left
  input  wire logic [OUT_DATA_W-1:0] m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output int                         mismatches,
  output int                         pending
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   granted;
    logic [CNT_W-1:0]    left;
  } frame_resp_t;

  // Shadow configuration
  logic [CFG_W-1:0]  total_pages_q  = TOTAL_PAGES_RST;
  logic [CFG_W-1:0]  kernel_pages_q = KERNEL_PAGES_RST;
  logic [CFG_W-1:0]  heap_pages_q   = HEAP_PAGES_RST;

  // Shadow page table and free list
  logic [FLAG_W-1:0] frame_flags [MAX_PAGES];
  logic [PAGE_W-1:0] free_fifo   [MAX_PAGES];
  logic [PAGE_W-1:0] fifo_rd = '0;
  logic [PAGE_W-1:0] fifo_wr = '0;
  int unsigned       free_frames = 0;

  frame_resp_t       due_responses [$];
  frame_resp_t       due_resp;
  frame_resp_t       seen_resp;
  int                error_count = 0;

  // Total clamped to the size of the page table
  function automatic int unsigned usable_pages();
    return (total_pages_q > MAX_PAGES) ? MAX_PAGES : int'(total_pages_q);
  endfunction

  function automatic void queue_free_frame(input logic [PAGE_W-1:0] pg);
    free_fifo[fifo_wr] = pg;
    fifo_wr            = fifo_wr + 1'b1;
    free_frames        = free_frames + 1;
  endfunction

  // Apply one request to the shadow state and return the response it must give
  function automatic frame_resp_t predict_frame_request(input logic [MODE_W-1:0] mode,
                                                        input logic [PAGE_W-1:0] page);
    frame_resp_t r;
    int unsigned limit;
    r.status  = STATUS_OK;
    r.granted = '0;
    case (mode)
      MODE_INIT: begin
        limit       = usable_pages();
        fifo_rd     = '0;
        fifo_wr     = '0;
        free_frames = 0;
        for (int i = 0; i < MAX_PAGES; i++) begin
          if (i >= limit) begin
            frame_flags[i] = FLAGS_NONE;
          end else if (i < kernel_pages_q) begin
            frame_flags[i] = FLAGS_KERNEL;
          end else if (i < kernel_pages_q + heap_pages_q) begin
            frame_flags[i] = FLAGS_HEAP;
          end else begin
            frame_flags[i] = FLAGS_NONE;
            queue_free_frame(PAGE_W'(i));
          end
        end
      end
      MODE_ALLOC: begin
        if (free_frames == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.granted   = free_fifo[fifo_rd];
          fifo_rd     = fifo_rd + 1'b1;
          free_frames = free_frames - 1;
          frame_flags[r.granted][FLAG_ALLOC_BIT]  = 1'b1;
          frame_flags[r.granted][FLAG_KERNEL_BIT] = 1'b1;
        end
      end
      MODE_FREE: begin
        if (page >= usable_pages() || !frame_flags[page][FLAG_ALLOC_BIT] ||
            free_frames >= MAX_PAGES) begin
          r.status = STATUS_BAD_PAGE;
        end else begin
          frame_flags[page][FLAG_ALLOC_BIT] = 1'b0;
          queue_free_frame(page);
        end
      end
      default: ;
    endcase
    r.left = CNT_W'(free_frames);
    return r;
  endfunction

  // Track config writes, predict on request, compare on response
  always @(posedge clk) begin
    if (rst) begin
      total_pages_q  = TOTAL_PAGES_RST;
      kernel_pages_q = KERNEL_PAGES_RST;
      heap_pages_q   = HEAP_PAGES_RST;
      for (int i = 0; i < MAX_PAGES; i++) frame_flags[i] = FLAGS_NONE;
      fifo_rd     = '0;
      fifo_wr     = '0;
      free_frames = 0;
      due_responses.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TOTAL_PAGES:  total_pages_q  = cfg_data;
          REG_KERNEL_PAGES: kernel_pages_q = cfg_data;
          REG_HEAP_PAGES:   heap_pages_q   = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        due_responses.push_back(predict_frame_request(s_tdata[MODE_W-1:0],
                                                      s_tdata[MODE_W+PAGE_W-1:MODE_W]));
      end
      if (m_tvalid && m_tready) begin
        seen_resp.status  = m_tdata[STATUS_W-1:0];
        seen_resp.granted = m_tdata[STATUS_W+PAGE_W-1:STATUS_W];
        seen_resp.left    = m_tdata[STATUS_W+PAGE_W+CNT_W-1:STATUS_W+PAGE_W];
        if (due_responses.size() == 0) begin
          $display("%0t frame check: response with no request outstanding, got %h",
                   $time, seen_resp);
          error_count++;
        end else begin
          due_resp = due_responses.pop_front();
          if (seen_resp.status !== due_resp.status) begin
            $display("%0t frame check: status expected %0d got %0d",
                     $time, due_resp.status, seen_resp.status);
            error_count++;
          end
          if (seen_resp.granted !== due_resp.granted) begin
            $display("%0t frame check: granted_page expected %0d got %0d",
                     $time, due_resp.granted, seen_resp.granted);
            error_count++;
          end
          if (seen_resp.left !== due_resp.left) begin
            $display("%0t frame check: free_pages_left expected %0d got %0d",
                     $time, due_resp.left, seen_resp.left);
            error_count++;
          end
        end
      end
    end
    mismatches <= error_count;
    pending    <= due_responses.size();
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  import pfa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int RANDOM_ITEMS = 550;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;

  int mismatches;
  int pending;
  int burst_left  = 0;
  int stall_level = 0;
  int stall_timer = 0;
  int cycle_count = 0;
  // programmed total, clamped, used to aim frees at real pages
  int unsigned live_total = MAX_PAGES;

  page_frame_allocator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_alloc_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver back-pressure: stall density is redrawn whenever its timer runs out
  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_level <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(16, 96);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    m_tready <= ($urandom_range(0, 3) >= stall_level);
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Present one request and hold it until accepted; bursts with random gaps
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [PAGE_W-1:0] page);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-MODE_W-PAGE_W){1'b0}}, page, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  // Hold off new requests until every response has come back
  task automatic drain_responses();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write all three registers on consecutive cycles
  task automatic program_config(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] kpages,
                                input logic [CFG_W-1:0] hpages);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TOTAL_PAGES;
    cfg_data  <= total;
    @(posedge clk);
    cfg_index <= REG_KERNEL_PAGES;
    cfg_data  <= kpages;
    @(posedge clk);
    cfg_index <= REG_HEAP_PAGES;
    cfg_data  <= hpages;
    @(posedge clk);
    cfg_we <= 1'b0;
    live_total = (total > MAX_PAGES) ? MAX_PAGES : int'(total);
  endtask

  initial begin
    int               issued;
    int               pick;
    int               upper;
    logic [CFG_W-1:0] total;
    logic [CFG_W-1:0] kpages;
    logic [CFG_W-1:0] hpages;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Before any init: free is rejected, alloc finds nothing, unused mode is a no-op
    send_request(MODE_FREE, 12'd12);
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_UNUSED, 12'hFFF);
    // Reset configuration: heap pages reserved at the bottom
    send_request(MODE_INIT, 12'd0);
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_FREE, 12'd0);
    send_request(MODE_FREE, 12'd0);
    send_request(MODE_FREE, 12'hFFF);

    // Tiny memory: run the list dry, free kernel and out-of-range pages
    drain_responses();
    program_config(13'd6, 13'd2, 13'd2);
    send_request(MODE_INIT, 12'd0);
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_FREE, 12'd6);
    send_request(MODE_FREE, 12'd1);
    send_request(MODE_FREE, 12'd4);
    send_request(MODE_ALLOC, 12'd0);

    // Shrink the total without init: range check follows the new total
    drain_responses();
    program_config(13'd3, 13'd2, 13'd2);
    send_request(MODE_FREE, 12'd5);
    send_request(MODE_FREE, 12'd2);

    // Total above the table size, everything reserved
    drain_responses();
    program_config(13'h1FFF, 13'd4096, 13'd4096);
    send_request(MODE_INIT, 12'd0);
    send_request(MODE_ALLOC, 12'd0);
    send_request(MODE_FREE, 12'hFFF);
    send_request(MODE_ALLOC, 12'd0);

    // No memory at all
    drain_responses();
    program_config(13'd0, 13'd0, 13'd0);
    send_request(MODE_INIT, 12'd0);
    send_request(MODE_FREE, 12'd0);

    // Whole table free
    drain_responses();
    program_config(13'd4096, 13'd0, 13'd0);
    send_request(MODE_INIT, 12'd0);
    send_request(MODE_FREE, 12'd0);
    send_request(MODE_ALLOC, 12'd0);

    // Random phases: new configuration, init, then mostly alloc and free traffic
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      drain_responses();
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          total  = 13'd4096;
          kpages = 13'd0;
          hpages = 13'd0;
        end
        1: begin
          total  = CFG_W'($urandom_range(4097, 8191));
          kpages = ($urandom_range(0, 1) == 0) ? 13'd4096 : CFG_W'($urandom_range(0, 64));
          hpages = ($urandom_range(0, 1) == 0) ? 13'd4096 : CFG_W'($urandom_range(0, 64));
        end
        2: begin
          total  = 13'd0;
          kpages = CFG_W'($urandom_range(0, 8));
          hpages = CFG_W'($urandom_range(0, 8));
        end
        default: begin
          total  = CFG_W'($urandom_range(1, 48));
          kpages = CFG_W'($urandom_range(0, total));
          hpages = CFG_W'($urandom_range(0, total));
        end
      endcase
      program_config(total, kpages, hpages);
      send_request(MODE_INIT, PAGE_W'($urandom_range(0, 4095)));
      issued++;

      repeat ($urandom_range(20, 60)) begin
        pick  = $urandom_range(0, 99);
        upper = (live_total + 1 > 4095) ? 4095 : int'(live_total) + 1;
        if (pick < 3) begin
          send_request(MODE_INIT, PAGE_W'($urandom_range(0, 4095)));
        end else if (pick < 8) begin
          send_request(MODE_UNUSED, PAGE_W'($urandom_range(0, 4095)));
        end else if (pick < 16) begin
          send_request(MODE_FREE, PAGE_W'($urandom_range(0, 4095)));
        end else if (pick < 56) begin
          send_request(MODE_ALLOC, PAGE_W'($urandom_range(0, 4095)));
        end else begin
          send_request(MODE_FREE, PAGE_W'($urandom_range(0, upper)));
        end
        issued++;
      end
    end

    // Wait out the last responses, then a short quiet period
    drain_responses();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
